// File: rtl/unique_value_set_table_defines.svh
// assertion macros for the unique value set table
`ifndef UNIQUE_VALUE_SET_TABLE_DEFINES_SVH
`define UNIQUE_VALUE_SET_TABLE_DEFINES_SVH

`ifndef SYNTHESIS

`define UVST_ASSERT(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

`define UVST_ASSERT_ALWAYS(name, clk, prop, msg) \
	name: assert property (@(posedge clk) prop) else $error(msg);

`else

`define UVST_ASSERT(name, clk, rst_n, prop, msg)

`define UVST_ASSERT_ALWAYS(name, clk, prop, msg)

`endif

`endif

// File: rtl/uvst_pkg.sv
// shared types and constants for the unique value set table
package uvst_pkg;

	localparam int DATA_W = 32;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;
	localparam int ADDR_W = 3;

	localparam logic [ADDR_W-1:0] REG_CAPACITY_ADDR = 3'd0;
	localparam logic [CNT_W-1:0] CAPACITY_RESET = 7'd64;

	typedef enum logic [1:0] {
		REQ_ADD = 2'd0,
		REQ_REMOVE = 2'd1,
		REQ_FIND = 2'd2,
		REQ_GET = 2'd3
	} req_kind_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0,
		ST_PRESENT = 3'd1,
		ST_NOT_FOUND = 3'd2,
		ST_FULL = 3'd3,
		ST_RANGE = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_CMP,
		S_ENC,
		S_UPD
	} state_t;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [DATA_W-1:0] value;
		logic [POS_W-1:0] position;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic [POS_W-1:0] found_index;
		logic signed [DATA_W-1:0] data;
		logic [CNT_W-1:0] count;
	} rsp_t;

	typedef struct packed {
		logic load_match;
		logic match_pos;
		logic add;
		logic shift;
	} cell_ctrl_t;

endpackage

// File: rtl/uvst_cell.sv
// one table entry: local compare, append write and shift from the next cell
module uvst_cell #(
	parameter int INDEX = 0,
	parameter int IW = 6,
	parameter int FW = 7
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  uvst_pkg::cell_ctrl_t                  ctrl,
	input  logic signed [uvst_pkg::DATA_W-1:0]    value,
	input  logic [uvst_pkg::POS_W-1:0]            position,
	input  logic [FW-1:0]                         filled,
	input  logic [IW-1:0]                         rm_idx,
	input  logic signed [uvst_pkg::DATA_W-1:0]    next_entry,
	output logic signed [uvst_pkg::DATA_W-1:0]    entry,
	output logic                                  match
);

	localparam logic [31:0] CELL_ID = 32'(INDEX);

	logic signed [uvst_pkg::DATA_W-1:0] entry_q;
	logic match_q;
	logic occupied;
	logic hit;

	assign occupied = CELL_ID < 32'(filled);
	assign hit = ctrl.match_pos ? (32'(position) == CELL_ID) : (entry_q == value);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.load_match) begin
			match_q <= occupied && hit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.add && (32'(filled) == CELL_ID)) begin
			entry_q <= value;
		end else if (ctrl.shift && (32'(rm_idx) <= CELL_ID)) begin
			entry_q <= next_entry;
		end
	end

	assign entry = entry_q;
	assign match = match_q;

endmodule

// File: rtl/uvst_enc.sv
// registered encoder of the single matching cell: hit flag, index and entry
module uvst_enc #(
	parameter int DEPTH = 64,
	parameter int IW = 6
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  load,
	input  logic [DEPTH-1:0]                      match,
	input  logic signed [uvst_pkg::DATA_W-1:0]    entry [DEPTH],
	output logic                                  hit,
	output logic [IW-1:0]                         idx,
	output logic signed [uvst_pkg::DATA_W-1:0]    rdata
);

	logic hit_q;
	logic [IW-1:0] idx_q;
	logic signed [uvst_pkg::DATA_W-1:0] rdata_q;
	logic [IW-1:0] idx_d;
	logic signed [uvst_pkg::DATA_W-1:0] rdata_d;

	// at most one cell matches, so an or over the cells encodes it
	always_comb begin
		idx_d = '0;
		rdata_d = '0;
		for (int i = 0; i < DEPTH; i++) begin
			if (match[i]) begin
				idx_d = idx_d | IW'(i);
				rdata_d = rdata_d | entry[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q <= 1'b0;
		end else if (load) begin
			hit_q <= |match;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= idx_d;
			rdata_q <= rdata_d;
		end
	end

	assign hit = hit_q;
	assign idx = idx_q;
	assign rdata = rdata_q;

endmodule

// File: rtl/unique_value_set_table.sv
// Set of distinct 32-bit values held in a row of DEPTH cells, packed in insertion
// order. After the accept edge a request passes a compare step, where every occupied
// cell compares its entry (or its index, for get) in parallel, an encode step that
// registers the single matching cell, and an update step that updates the row (append
// into the cell at the fill count, or every cell at and above the removed index takes
// its neighbor's entry) and loads the result register. One request is in flight at a
// time; the next is accepted at the edge after the result is loaded, and a result not
// yet taken holds the update step. Entries have no reset and need no clearing pass:
// only cells below the fill count are ever compared or read. The capacity register
// limits adds to min(capacity, DEPTH).
`include "unique_value_set_table_defines.svh"

module unique_value_set_table #(
	parameter int DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_ready,
	input  uvst_pkg::req_t                    req,
	output logic                              rsp_valid,
	input  logic                              rsp_ready,
	output uvst_pkg::rsp_t                    rsp,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [uvst_pkg::ADDR_W-1:0]       paddr,
	input  logic [31:0]                       pwdata,
	output logic [31:0]                       prdata,
	output logic                              pready
);

	localparam int IW = $clog2(DEPTH);
	localparam int FW = $clog2(DEPTH + 1);
	localparam int LW = (FW > uvst_pkg::CNT_W) ? FW : uvst_pkg::CNT_W;

	uvst_pkg::state_t state_q, state_d;
	uvst_pkg::req_t req_q;
	uvst_pkg::rsp_t rsp_q, rsp_d;
	uvst_pkg::cell_ctrl_t ctrl;
	logic rsp_valid_q;
	logic [FW-1:0] filled_q;
	logic [uvst_pkg::CNT_W-1:0] capacity_q;
	logic [LW-1:0] limit;
	logic full;
	logic commit;
	logic enc_load;
	logic do_add;
	logic do_rm;

	logic [DEPTH-1:0] match;
	logic signed [uvst_pkg::DATA_W-1:0] entry_w [DEPTH];
	logic hit;
	logic [IW-1:0] hit_idx;
	logic signed [uvst_pkg::DATA_W-1:0] hit_data;

	// configuration port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= uvst_pkg::CAPACITY_RESET;
		end else if (psel && penable && pwrite && (paddr == uvst_pkg::REG_CAPACITY_ADDR)) begin
			capacity_q <= pwdata[uvst_pkg::CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr == uvst_pkg::REG_CAPACITY_ADDR) begin
			prdata = 32'(capacity_q);
		end
	end

	// cell row
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic signed [uvst_pkg::DATA_W-1:0] next_entry;
		if (i == DEPTH - 1) begin : g_last
			assign next_entry = entry_w[i];
		end else begin : g_mid
			assign next_entry = entry_w[i+1];
		end
		uvst_cell #(
			.INDEX(i),
			.IW(IW),
			.FW(FW)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.value(req_q.value),
			.position(req_q.position),
			.filled(filled_q),
			.rm_idx(hit_idx),
			.next_entry(next_entry),
			.entry(entry_w[i]),
			.match(match[i])
		);
	end

	uvst_enc #(
		.DEPTH(DEPTH),
		.IW(IW)
	) u_enc (
		.clk(clk),
		.arst_n(arst_n),
		.load(enc_load),
		.match(match),
		.entry(entry_w),
		.hit(hit),
		.idx(hit_idx),
		.rdata(hit_data)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= uvst_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			uvst_pkg::S_IDLE: begin
				if (req_valid) begin
					state_d = uvst_pkg::S_CMP;
				end
			end
			uvst_pkg::S_CMP: state_d = uvst_pkg::S_ENC;
			uvst_pkg::S_ENC: state_d = uvst_pkg::S_UPD;
			uvst_pkg::S_UPD: begin
				if (!rsp_valid_q || rsp_ready) begin
					state_d = uvst_pkg::S_IDLE;
				end
			end
			default: state_d = uvst_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		req_ready = 1'b0;
		enc_load = 1'b0;
		commit = 1'b0;
		ctrl = '0;
		ctrl.match_pos = (req_q.req_type == uvst_pkg::REQ_GET);
		unique case (state_q)
			uvst_pkg::S_IDLE: req_ready = 1'b1;
			uvst_pkg::S_CMP: ctrl.load_match = 1'b1;
			uvst_pkg::S_ENC: enc_load = 1'b1;
			uvst_pkg::S_UPD: commit = !rsp_valid_q || rsp_ready;
			default: req_ready = 1'b0;
		endcase
		ctrl.add = commit && do_add;
		ctrl.shift = commit && do_rm;
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_q <= req;
		end
	end

	// result and fill count
	assign limit = (LW'(capacity_q) < LW'(DEPTH)) ? LW'(capacity_q) : LW'(DEPTH);
	assign full = LW'(filled_q) >= limit;

	always_comb begin
		rsp_d = '0;
		do_add = 1'b0;
		do_rm = 1'b0;
		rsp_d.status = uvst_pkg::ST_OK;
		rsp_d.count = uvst_pkg::CNT_W'(filled_q);
		unique case (uvst_pkg::req_kind_t'(req_q.req_type))
			uvst_pkg::REQ_ADD: begin
				if (hit) begin
					rsp_d.status = uvst_pkg::ST_PRESENT;
					rsp_d.found_index = uvst_pkg::POS_W'(hit_idx);
				end else if (full) begin
					rsp_d.status = uvst_pkg::ST_FULL;
				end else begin
					do_add = 1'b1;
					rsp_d.found_index = uvst_pkg::POS_W'(filled_q);
					rsp_d.count = uvst_pkg::CNT_W'(filled_q + FW'(1));
				end
			end
			uvst_pkg::REQ_REMOVE: begin
				if (hit) begin
					do_rm = 1'b1;
					rsp_d.found_index = uvst_pkg::POS_W'(hit_idx);
					rsp_d.count = uvst_pkg::CNT_W'(filled_q - FW'(1));
				end else begin
					rsp_d.status = uvst_pkg::ST_NOT_FOUND;
				end
			end
			uvst_pkg::REQ_FIND: begin
				if (hit) begin
					rsp_d.found_index = uvst_pkg::POS_W'(hit_idx);
				end else begin
					rsp_d.status = uvst_pkg::ST_NOT_FOUND;
				end
			end
			uvst_pkg::REQ_GET: begin
				if (hit) begin
					rsp_d.found_index = uvst_pkg::POS_W'(hit_idx);
					rsp_d.data = hit_data;
				end else begin
					rsp_d.status = uvst_pkg::ST_RANGE;
				end
			end
			default: rsp_d.status = uvst_pkg::ST_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= '0;
		end else if (commit && do_add) begin
			filled_q <= filled_q + FW'(1);
		end else if (commit && do_rm) begin
			filled_q <= filled_q - FW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (commit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (commit) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	`UVST_ASSERT_ALWAYS(a_single_match, clk, !arst_n || $onehot0(match), "more than one cell matches")
	`UVST_ASSERT(a_fill_bound, clk, arst_n, filled_q <= FW'(DEPTH), "fill count beyond depth")
	`UVST_ASSERT(a_fill_only_on_update, clk, arst_n,
		!$stable(filled_q) |-> $past(state_q) == uvst_pkg::S_UPD,
		"fill count changed outside update")
	`UVST_ASSERT(a_hold_on_stall, clk, arst_n,
		(state_q == uvst_pkg::S_UPD) && rsp_valid_q && !rsp_ready |=> state_q == uvst_pkg::S_UPD,
		"update step left while result pending")

endmodule

// File: sim/unique_value_set_table_checker.sv
// checker for the unique value set table: tracks the set from observed traffic and compares results
`timescale 1ns / 1ps

module unique_value_set_table_checker #(
	parameter int DEPTH = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        req_valid,
	input  logic                        req_ready,
	input  uvst_pkg::req_t              req,
	input  logic                        rsp_valid,
	input  logic                        rsp_ready,
	input  uvst_pkg::rsp_t              rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [uvst_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          fail_count,
	output int                          results_owed
);

	logic [uvst_pkg::DATA_W-1:0] members [DEPTH];
	int filled;
	int capacity;
	uvst_pkg::rsp_t owed_q[$];
	uvst_pkg::rsp_t want;

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		fail_count++;
	endtask

	function automatic uvst_pkg::rsp_t set_update(input uvst_pkg::req_t item);
		uvst_pkg::rsp_t o;
		int lim;
		int at;
		int i;
		bit hit;
		o = '0;
		o.status = uvst_pkg::ST_OK;
		lim = (capacity < DEPTH) ? capacity : DEPTH;
		hit = 1'b0;
		at = 0;
		for (i = 0; i < filled; i++) begin
			if (!hit && members[i] == item.value) begin
				hit = 1'b1;
				at = i;
			end
		end
		case (uvst_pkg::req_kind_t'(item.req_type))
			uvst_pkg::REQ_ADD: begin
				if (hit) begin
					o.status = uvst_pkg::ST_PRESENT;
					o.found_index = at[uvst_pkg::POS_W-1:0];
				end else if (filled >= lim) begin
					o.status = uvst_pkg::ST_FULL;
				end else begin
					members[filled] = item.value;
					o.found_index = filled[uvst_pkg::POS_W-1:0];
					filled++;
				end
			end
			uvst_pkg::REQ_REMOVE: begin
				if (hit) begin
					o.found_index = at[uvst_pkg::POS_W-1:0];
					for (i = at; i + 1 < filled; i++)
						members[i] = members[i + 1];
					filled--;
				end else begin
					o.status = uvst_pkg::ST_NOT_FOUND;
				end
			end
			uvst_pkg::REQ_FIND: begin
				if (hit)
					o.found_index = at[uvst_pkg::POS_W-1:0];
				else
					o.status = uvst_pkg::ST_NOT_FOUND;
			end
			default: begin
				if (int'(item.position) < filled) begin
					o.found_index = item.position;
					o.data = members[item.position];
				end else begin
					o.status = uvst_pkg::ST_RANGE;
				end
			end
		endcase
		o.count = filled[uvst_pkg::CNT_W-1:0];
		return o;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fail_count = 0;
			filled = 0;
			capacity = int'(uvst_pkg::CAPACITY_RESET);
			owed_q.delete();
			results_owed <= 0;
		end else begin
			if (psel && penable && pready && paddr == uvst_pkg::REG_CAPACITY_ADDR) begin
				if (pwrite)
					capacity = int'(pwdata[uvst_pkg::CNT_W-1:0]);
				else if (prdata[uvst_pkg::CNT_W-1:0] !== capacity[uvst_pkg::CNT_W-1:0])
					report_mismatch($sformatf("capacity read %0d, want %0d",
						prdata[uvst_pkg::CNT_W-1:0], capacity));
			end
			if (rsp_valid && rsp_ready) begin
				if (owed_q.size() == 0) begin
					report_mismatch($sformatf("result with no request pending, status %0d",
						rsp.status));
				end else begin
					want = owed_q.pop_front();
					if (rsp.status !== want.status)
						report_mismatch($sformatf("status %0d, want %0d",
							rsp.status, want.status));
					if (rsp.found_index !== want.found_index)
						report_mismatch($sformatf("found_index %0d, want %0d",
							rsp.found_index, want.found_index));
					if (rsp.data !== want.data)
						report_mismatch($sformatf("data %0d, want %0d",
							rsp.data, want.data));
					if (rsp.count !== want.count)
						report_mismatch($sformatf("count %0d, want %0d",
							rsp.count, want.count));
				end
			end
			if (req_valid && req_ready)
				owed_q.push_back(set_update(req));
			results_owed <= owed_q.size();
		end
	end

endmodule

// File: sim/unique_value_set_table_tb.sv
// testbench top for the unique value set table: request and capacity stimulus, final verdict
`timescale 1ns / 1ps

module unique_value_set_table_tb;

	localparam int DEPTH = 64;
	localparam int POOL_MAX = 80;
	localparam logic [uvst_pkg::DATA_W-1:0] VAL_MAX = 32'h7FFF_FFFF;
	localparam logic [uvst_pkg::DATA_W-1:0] VAL_MIN = 32'h8000_0000;
	localparam logic [uvst_pkg::DATA_W-1:0] VAL_NEG1 = 32'hFFFF_FFFF;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_ready;
	uvst_pkg::req_t req;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	uvst_pkg::rsp_t rsp;
	logic psel;
	logic penable;
	logic pwrite;
	logic [uvst_pkg::ADDR_W-1:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	int fail_count;
	int results_owed;
	int rsp_stall = 0;
	int stall_draw;
	bit no_idle;
	logic [uvst_pkg::DATA_W-1:0] pool [POOL_MAX];
	int pool_n;

	unique_value_set_table #(.DEPTH(DEPTH)) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	unique_value_set_table_checker #(.DEPTH(DEPTH)) u_checker (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp(rsp),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.fail_count(fail_count),
		.results_owed(results_owed)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// result side: hold ready low for a drawn number of cycles after each transaction
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ready <= 1'b0;
			rsp_stall <= 0;
		end else if (rsp_valid && rsp_ready) begin
			stall_draw = no_idle ? 0 : $urandom_range(0, 3);
			rsp_stall <= stall_draw;
			rsp_ready <= (stall_draw == 0);
		end else if (rsp_stall > 1) begin
			rsp_stall <= rsp_stall - 1;
		end else begin
			rsp_stall <= 0;
			rsp_ready <= 1'b1;
		end
	end

	task automatic send_item(input uvst_pkg::req_kind_t kind,
			input logic [uvst_pkg::DATA_W-1:0] val, input logic [uvst_pkg::POS_W-1:0] pos);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= '{req_type: kind, value: val, position: pos};
		do @(posedge clk); while (req_ready !== 1'b1);
	endtask

	task automatic wait_idle();
		req_valid <= 1'b0;
		@(posedge clk);
		wait (results_owed == 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_xfer(input bit wr, input logic [uvst_pkg::ADDR_W-1:0] addr,
			input logic [31:0] wdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= addr;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_capacity(input int cap);
		wait_idle();
		apb_xfer(1'b1, uvst_pkg::REG_CAPACITY_ADDR, cap);
		apb_xfer(1'b0, uvst_pkg::REG_CAPACITY_ADDR, '0);
	endtask

	task automatic new_pool(input int n);
		int i;
		pool_n = n;
		for (i = 0; i < n; i++) begin
			case ($urandom_range(0, 11))
				0: pool[i] = VAL_MAX;
				1: pool[i] = VAL_MIN;
				2: pool[i] = VAL_NEG1;
				3: pool[i] = '0;
				default: pool[i] = $urandom();
			endcase
		end
	endtask

	task automatic random_phase(input int n, input int add_pct, input int rem_pct);
		int k;
		int r;
		uvst_pkg::req_kind_t kind;
		logic [uvst_pkg::DATA_W-1:0] val;
		logic [uvst_pkg::POS_W-1:0] pos;
		for (k = 0; k < n; k++) begin
			if (k % 40 == 0)
				no_idle = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 99);
			if (r < add_pct)
				kind = uvst_pkg::REQ_ADD;
			else if (r < add_pct + rem_pct)
				kind = uvst_pkg::REQ_REMOVE;
			else if (r[0])
				kind = uvst_pkg::REQ_FIND;
			else
				kind = uvst_pkg::REQ_GET;
			val = pool[$urandom_range(0, pool_n - 1)];
			// values outside the pool never get added, so a drain empties the set
			if (kind != uvst_pkg::REQ_ADD && $urandom_range(0, 6) == 0)
				val = $urandom();
			pos = $urandom_range(0, 1) ? uvst_pkg::POS_W'($urandom_range(0, 63)) :
				uvst_pkg::POS_W'($urandom_range(0, 15));
			send_item(kind, val, pos);
		end
		no_idle = 1'b0;
	endtask

	task automatic drain_pool();
		logic [uvst_pkg::DATA_W-1:0] order [POOL_MAX];
		logic [uvst_pkg::DATA_W-1:0] tmp;
		int i;
		int j;
		for (i = 0; i < pool_n; i++)
			order[i] = pool[i];
		for (i = pool_n - 1; i > 0; i--) begin
			j = $urandom_range(0, i);
			tmp = order[i];
			order[i] = order[j];
			order[j] = tmp;
		end
		for (i = 0; i < pool_n; i++)
			send_item(uvst_pkg::REQ_REMOVE, order[i], uvst_pkg::POS_W'($urandom()));
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		pool_n = 1;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty table, extremes, duplicate add, removal with shift
		send_item(uvst_pkg::REQ_GET, '0, '0);
		send_item(uvst_pkg::REQ_FIND, 32'd5, '0);
		send_item(uvst_pkg::REQ_REMOVE, 32'd5, '0);
		send_item(uvst_pkg::REQ_ADD, VAL_MAX, '0);
		send_item(uvst_pkg::REQ_ADD, VAL_MIN, '0);
		send_item(uvst_pkg::REQ_ADD, '0, '0);
		send_item(uvst_pkg::REQ_ADD, VAL_NEG1, '0);
		send_item(uvst_pkg::REQ_ADD, VAL_MIN, '0);
		send_item(uvst_pkg::REQ_FIND, VAL_NEG1, '0);
		send_item(uvst_pkg::REQ_GET, VAL_NEG1, '1);
		send_item(uvst_pkg::REQ_GET, '0, 6'd1);
		send_item(uvst_pkg::REQ_REMOVE, VAL_MIN, '0);
		send_item(uvst_pkg::REQ_GET, '0, 6'd1);
		send_item(uvst_pkg::REQ_GET, '0, 6'd2);
		send_item(uvst_pkg::REQ_GET, '0, 6'd3);
		// capacity lowered below the fill count
		write_capacity(2);
		send_item(uvst_pkg::REQ_ADD, 32'd7, '0);
		send_item(uvst_pkg::REQ_FIND, '0, '0);
		send_item(uvst_pkg::REQ_REMOVE, VAL_MAX, '0);
		send_item(uvst_pkg::REQ_ADD, 32'd7, '0);
		send_item(uvst_pkg::REQ_REMOVE, '0, '0);
		send_item(uvst_pkg::REQ_ADD, 32'd7, '0);
		write_capacity(0);
		send_item(uvst_pkg::REQ_ADD, 32'd9, '0);
		send_item(uvst_pkg::REQ_ADD, 32'd7, '0);
		send_item(uvst_pkg::REQ_REMOVE, VAL_NEG1, '0);
		send_item(uvst_pkg::REQ_REMOVE, 32'd7, '0);

		write_capacity(64);
		new_pool(72);
		random_phase(150, 60, 10);
		write_capacity(3);
		random_phase(60, 40, 20);
		drain_pool();
		write_capacity(0);
		random_phase(40, 40, 10);
		write_capacity(127);
		new_pool(72);
		random_phase(70, 55, 15);
		drain_pool();
		write_capacity(1);
		new_pool(4);
		random_phase(60, 40, 25);
		write_capacity(64);
		new_pool(24);
		random_phase(50, 35, 25);
		wait_idle();

		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/uvst_pkg.sv
rtl/uvst_cell.sv
rtl/uvst_enc.sv
rtl/unique_value_set_table.sv
sim/unique_value_set_table_checker.sv
sim/unique_value_set_table_tb.sv
